// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the RTL of the status LED blinker.
// Included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every rising clock edge outside reset.
`define CHK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the next cycle.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// ----- rtl/core/psled_pkg.sv -----
// Package for the priority status LED blinker.
// Holds sizes, command codes and the shared entry, scan and write types.
package psled_pkg;
  localparam int unsigned Slots    = 8;
  localparam int unsigned KeyWidth = 16;
  localparam int unsigned SlotW    = $clog2(Slots);

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_SET_ACT = 3'd1,
    CMD_SET_PRI = 3'd2,
    CMD_DISPLAY = 3'd3,
    CMD_UPDATE  = 3'd4
  } cmd_e;

  // One table entry.
  typedef struct packed {
    logic                valid;
    logic [KeyWidth-1:0] key;
    logic                active;
    logic [2:0]          color;
    logic [15:0]         period;
    logic [7:0]          target;
    logic [7:0]          done;
    logic [7:0]          prio;
  } entry_t;

  // Scan token handed from cell to cell.
  typedef struct packed {
    logic                hit;
    logic [SlotW-1:0]    hit_slot;
    logic [7:0]          top_any;
    logic                best_ok;
    logic [7:0]          best_prio;
    logic [SlotW-1:0]    best_slot;
  } scan_t;

  // Write command from the controller to the cells.
  typedef struct packed {
    logic                we;
    logic [SlotW-1:0]    slot;
    entry_t              data;
  } wr_t;
endpackage

// ----- rtl/core/psled_cell.sv -----
// One table cell of the status LED blinker: holds an entry, folds it into
// the scan token. Depends on psled_pkg.
module psled_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [psled_pkg::SlotW-1:0]         my_slot_i,
  input  logic [psled_pkg::KeyWidth-1:0]      key_i,
  input  psled_pkg::scan_t                    scan_i,
  output psled_pkg::scan_t                    scan_o,
  input  psled_pkg::wr_t                      wr_i,
  output psled_pkg::entry_t                   entry_o
);
  psled_pkg::entry_t ent_q;

  // Hold the entry; clear it at reset, load it when this slot is written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else if (wr_i.we && wr_i.slot == my_slot_i) begin
      ent_q <= wr_i.data;
    end
  end

  assign entry_o = ent_q;

  // Fold this entry into the token: later slot wins key hits, earlier wins ties.
  always_comb begin
    scan_o = scan_i;
    if (ent_q.valid && ent_q.key == key_i) begin
      scan_o.hit      = 1'b1;
      scan_o.hit_slot = my_slot_i;
    end
    if (ent_q.prio > scan_i.top_any) scan_o.top_any = ent_q.prio;
    if (ent_q.valid && ent_q.active && ent_q.prio > scan_i.best_prio) begin
      scan_o.best_ok   = 1'b1;
      scan_o.best_prio = ent_q.prio;
      scan_o.best_slot = my_slot_i;
    end
  end
endmodule

// ----- rtl/core/priority_status_led_blinker_unit.sv -----
// Priority status LED blinker: input channel carries commands, output
// channel carries ok and the LED drive. Each command walks the cell row
// one slot per cycle, then applies its effect.
// Usage: present cmd and its fields with cmd_valid_i; the item is taken when
//   cmd_stall_o is low. One result follows per command on res_valid_o.
// Display now with a key hit rescans the row before its refresh; the next
//   command is taken while the previous result waits in the output
//   register.
// The scan token advances one cell per cycle through a row of Slots cells.
// Reset clears every entry, the round-robin slot, the blink state and the
//   LED drive; no result is pending.
// A stalled receiver holds the result steady; a further command is taken
//   but its result waits until the earlier one is delivered.
// Unknown commands give ok low and the present LED drive.
module priority_status_led_blinker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_stall_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] status_key_i,
  input  logic [2:0]  led_color_i,
  input  logic [7:0]  prio_level_i,
  input  logic [15:0] blink_period_i,
  input  logic [7:0]  blink_target_i,
  input  logic        make_active_i,
  input  logic [31:0] now_ms_i,
  output logic        res_valid_o,
  input  logic        res_stall_i,
  output logic        ok_o,
  output logic [2:0]  led_rgb_o
);
  `include "assert_macros.svh"

  localparam int unsigned SW = psled_pkg::SlotW;
  localparam int unsigned CW = $clog2(psled_pkg::Slots + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY, ST_DISP} state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q;
  logic [2:0]  cmd_q;
  logic [psled_pkg::KeyWidth-1:0] key_q;
  logic [2:0]  color_q;
  logic [7:0]  prio_q, target_q;
  logic [15:0] period_q;
  logic        mk_q;
  logic [31:0] now_q;
  psled_pkg::scan_t tok_q, tok_d;
  psled_pkg::scan_t scan_in [psled_pkg::Slots];
  psled_pkg::scan_t scan_out[psled_pkg::Slots];
  psled_pkg::entry_t ent[psled_pkg::Slots];
  psled_pkg::wr_t wr;

  logic [SW-1:0] next_slot_q;
  logic [SW:0]   shown_q;
  logic          blink_q, prev_q;
  logic [31:0]   last_q;
  logic [2:0]    drive_q;
  logic          res_pend_q, res_ok_q;
  logic [2:0]    res_led_q;
  logic          done_pulse;
  logic          done_ok;
  logic [2:0]    done_led;
  logic          res_free;
  logic          retire;

  // Row of cells; all see the token, only the counter's pick passes it on.
  for (genvar g = 0; g < psled_pkg::Slots; g++) begin : g_cell
    assign scan_in[g] = tok_q;
    psled_cell u_cell (
      .clk_i, .rst_ni,
      .my_slot_i(SW'(g)),
      .key_i(key_q),
      .scan_i(scan_in[g]),
      .scan_o(scan_out[g]),
      .wr_i(wr),
      .entry_o(ent[g])
    );
  end

  assign tok_d = scan_out[cnt_q[SW-1:0]];
  assign cmd_stall_o = (state_q != ST_IDLE);
  assign res_valid_o = res_pend_q;
  assign ok_o        = res_ok_q;
  assign led_rgb_o   = res_led_q;

  // Refresh: blink and drive from the best active entry found by the scan.
  logic          rf_sel_ok;
  logic [SW-1:0] rf_sel;
  psled_pkg::entry_t rf_e;
  logic          rf_blink, rf_toggle;
  logic          rf_blink_n, rf_prev_n;
  logic [7:0]    rf_done_n;
  logic [2:0]    rf_drive;
  logic [31:0]   rf_last_n;
  logic          rf_deact;

  always_comb begin
    rf_sel_ok  = tok_q.best_ok;
    rf_sel     = tok_q.best_slot;
    rf_e       = ent[rf_sel];
    rf_blink   = (shown_q != {1'b0, rf_sel}) ? 1'b0 : blink_q;
    rf_drive   = (rf_e.period == 16'd0 || rf_blink) ? rf_e.color : 3'd0;
    rf_toggle  = (now_q - last_q) > {16'd0, rf_e.period};
    rf_blink_n = rf_blink;
    rf_last_n  = last_q;
    rf_prev_n  = prev_q;
    rf_done_n  = rf_e.done;
    rf_deact   = 1'b0;
    if (rf_e.period != 16'd0) begin
      if (rf_toggle) begin
        rf_last_n  = now_q;
        rf_blink_n = ~rf_blink;
      end
      if (rf_e.target != 8'd0) begin
        if (rf_blink_n != prev_q && prev_q && rf_e.done != 8'hFF)
          rf_done_n = rf_e.done + 8'd1;
        rf_prev_n = rf_blink_n;
        rf_deact  = (rf_done_n >= rf_e.target);
      end
    end
    if (!rf_sel_ok) rf_drive = 3'd0;
  end

  // The result register can take a new transaction this cycle.
  assign res_free = !res_pend_q || !res_stall_i;

  // Apply-phase table write at retire; a display hit writes in ST_APPLY too.
  always_comb begin
    wr      = '0;
    wr.slot = tok_q.hit_slot;
    wr.data = ent[tok_q.hit_slot];
    done_ok = 1'b0;
    if (state_q == ST_APPLY && (res_free || cmd_q == psled_pkg::CMD_DISPLAY)) begin
      unique case (cmd_q)
        psled_pkg::CMD_CREATE: begin
          if (!tok_q.hit) begin
            wr.we   = 1'b1;
            wr.slot = next_slot_q;
            wr.data = '{valid: 1'b1, key: key_q, active: 1'b0, color: color_q,
                        period: period_q, target: target_q, done: 8'd0,
                        prio: prio_q};
            done_ok = 1'b1;
          end
        end
        psled_pkg::CMD_SET_ACT: begin
          wr.we          = tok_q.hit;
          wr.data.active = mk_q;
          wr.data.done   = 8'd0;
          done_ok        = tok_q.hit;
        end
        psled_pkg::CMD_SET_PRI: begin
          wr.we        = tok_q.hit;
          wr.data.prio = prio_q;
          done_ok      = tok_q.hit;
        end
        psled_pkg::CMD_DISPLAY: begin
          wr.we          = tok_q.hit;
          wr.data.active = 1'b1;
          wr.data.done   = 8'd0;
          wr.data.prio   = (tok_q.top_any == 8'hFF) ? 8'hFF : tok_q.top_any + 8'd1;
          done_ok        = tok_q.hit;
        end
        psled_pkg::CMD_UPDATE: begin
          wr.we          = rf_sel_ok;
          wr.slot        = rf_sel;
          wr.data        = rf_e;
          wr.data.done   = rf_done_n;
          wr.data.active = rf_e.active & ~rf_deact;
          done_ok        = 1'b1;
        end
        default: done_ok = 1'b0;
      endcase
    end else if (state_q == ST_DISP && cnt_q == CW'(psled_pkg::Slots) && res_free) begin
      // Display-now refresh from the second scan.
      wr.we          = rf_sel_ok;
      wr.slot        = rf_sel;
      wr.data        = rf_e;
      wr.data.done   = rf_done_n;
      wr.data.active = rf_e.active & ~rf_deact;
    end
  end

  assign done_pulse = (state_q == ST_APPLY && !(cmd_q == psled_pkg::CMD_DISPLAY && tok_q.hit))
                    || state_q == ST_DISP;
  assign done_led   = (cmd_q == psled_pkg::CMD_UPDATE || state_q == ST_DISP)
                    ? rf_drive : drive_q;
  assign retire     = ((state_q == ST_APPLY && done_pulse) ||
                       (state_q == ST_DISP && cnt_q == CW'(psled_pkg::Slots))) && res_free;

  // Capture the command fields.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) begin
      cmd_q    <= cmd_i;
      key_q    <= status_key_i;
      color_q  <= led_color_i;
      prio_q   <= prio_level_i;
      period_q <= blink_period_i;
      target_q <= blink_target_i;
      mk_q     <= make_active_i;
      now_q    <= now_ms_i;
    end
  end

  // Sequence scan and apply; hold blink state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      tok_q       <= '0;
      next_slot_q <= '0;
      shown_q     <= '0;
      blink_q     <= 1'b0;
      prev_q      <= 1'b0;
      last_q      <= '0;
      drive_q     <= '0;
      res_pend_q  <= 1'b0;
      res_ok_q    <= 1'b0;
      res_led_q   <= '0;
    end else begin
      res_pend_q <= retire | (res_pend_q & res_stall_i);
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            state_q <= ST_SCAN;
            cnt_q   <= '0;
            tok_q   <= '0;
          end
        end
        ST_SCAN: begin
          tok_q <= tok_d;
          if (cnt_q == CW'(psled_pkg::Slots - 1)) state_q <= ST_APPLY;
          else cnt_q <= cnt_q + 1'b1;
        end
        ST_APPLY: begin
          if (cmd_q == psled_pkg::CMD_DISPLAY && tok_q.hit) begin
            // Rescan with the new priority before the refresh.
            state_q <= ST_DISP;
            cnt_q   <= '0;
            tok_q   <= '0;
          end else if (res_free) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DISP: begin
          if (cnt_q != CW'(psled_pkg::Slots)) begin
            tok_q <= tok_d;
            cnt_q <= cnt_q + 1'b1;
          end else if (res_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (state_q == ST_APPLY && cmd_q == psled_pkg::CMD_CREATE && !tok_q.hit && res_free)
        next_slot_q <= next_slot_q + 1'b1;
      // Retire the command once the result register is free.
      if (retire) begin
        res_ok_q   <= (state_q == ST_DISP) ? 1'b1 : done_ok;
        res_led_q  <= done_led;
        if (cmd_q == psled_pkg::CMD_UPDATE || state_q == ST_DISP) begin
          drive_q <= rf_drive;
          if (rf_sel_ok) begin
            shown_q <= {1'b0, rf_sel};
            blink_q <= rf_blink_n;
            last_q  <= rf_last_n;
            prev_q  <= rf_prev_n;
          end
        end
      end
    end
  end

  `CHK(a_stall_busy, clk_i, rst_ni, (state_q == ST_IDLE) == !cmd_stall_o,
       "stall must follow busy state")
  `CHK_NEXT(a_take_scan, clk_i, rst_ni, state_q == ST_IDLE && cmd_valid_i,
            state_q == ST_SCAN && cnt_q == '0, "accepted command must start a scan")
  `CHK(a_cnt_range, clk_i, rst_ni, cnt_q <= CW'(psled_pkg::Slots),
       "scan counter beyond row")
endmodule

// ----- verif/tb.sv -----
// Testbench for priority_status_led_blinker_unit: directed and random command
// streams, checked against an in-bench model of the status table. Uses psled_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cmd_valid_i = 1'b0;
  logic        cmd_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [15:0] status_key_i = '0;
  logic [2:0]  led_color_i = '0;
  logic [7:0]  prio_level_i = '0;
  logic [15:0] blink_period_i = '0;
  logic [7:0]  blink_target_i = '0;
  logic        make_active_i = 1'b0;
  logic [31:0] now_ms_i = '0;
  logic        res_valid_o;
  logic        res_stall_i = 1'b0;
  logic        ok_o;
  logic [2:0]  led_rgb_o;

  priority_status_led_blinker_unit i_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Model state of the table
  logic        m_valid [psled_pkg::Slots];
  logic [15:0] m_key [psled_pkg::Slots];
  logic        m_active [psled_pkg::Slots];
  logic [2:0]  m_color [psled_pkg::Slots];
  logic [15:0] m_period [psled_pkg::Slots];
  logic [7:0]  m_target [psled_pkg::Slots];
  logic [7:0]  m_done [psled_pkg::Slots];
  logic [7:0]  m_prio [psled_pkg::Slots];
  logic [2:0]  m_next;
  logic [3:0]  m_shown;
  logic        m_blink, m_prev_blink;
  logic [31:0] m_last_ms;
  logic [2:0]  m_drive;

  logic [3:0] pending_q[$];  // {ok, led}
  int errors = 0;
  int sent = 0;
  int got = 0;
  int cycles = 0;
  bit hold_off = 1'b0;
  logic [31:0] clock_ms = 0;

  function automatic int find_key(logic [15:0] key);
    int hit = -1;
    for (int i = 0; i < psled_pkg::Slots; i++)
      if (m_valid[i] && m_key[i] == key) hit = i;
    return hit;
  endfunction

  function automatic void refresh_led(logic [31:0] now);
    int sel = -1;
    logic [7:0] best = 0;
    for (int i = 0; i < psled_pkg::Slots; i++) begin
      if (m_valid[i] && m_active[i] && m_prio[i] > best) begin
        best = m_prio[i];
        sel = i;
      end
    end
    if (sel < 0) begin
      m_drive = 0;
      return;
    end
    if (sel != m_shown) m_blink = 0;
    m_shown = 4'(sel);
    m_drive = (m_period[sel] == 0 || m_blink) ? m_color[sel] : 3'd0;
    if (m_period[sel] == 0) return;
    if (now - m_last_ms > {16'd0, m_period[sel]}) begin
      m_last_ms = now;
      m_blink = ~m_blink;
    end
    if (m_target[sel] == 0) return;
    if (m_blink != m_prev_blink && m_prev_blink && m_done[sel] != 8'hff)
      m_done[sel]++;
    m_prev_blink = m_blink;
    if (m_done[sel] >= m_target[sel]) m_active[sel] = 0;
  endfunction

  function automatic logic [3:0] predict_led(logic [2:0] cmd, logic [15:0] key,
      logic [2:0] color, logic [7:0] prio, logic [15:0] period, logic [7:0] target,
      logic act, logic [31:0] now);
    logic ok = 0;
    int idx = find_key(key);
    logic [7:0] top = 0;
    case (cmd)
      psled_pkg::CMD_CREATE: begin
        if (idx < 0) begin
          m_valid[m_next] = 1; m_key[m_next] = key; m_active[m_next] = 0;
          m_color[m_next] = color; m_period[m_next] = period;
          m_target[m_next] = target; m_done[m_next] = 0; m_prio[m_next] = prio;
          m_next = m_next + 3'd1;
          ok = 1;
        end
      end
      psled_pkg::CMD_SET_ACT: begin
        if (idx >= 0) begin
          m_active[idx] = act; m_done[idx] = 0; ok = 1;
        end
      end
      psled_pkg::CMD_SET_PRI: begin
        if (idx >= 0) begin
          m_prio[idx] = prio; ok = 1;
        end
      end
      psled_pkg::CMD_DISPLAY: begin
        if (idx >= 0) begin
          for (int i = 0; i < psled_pkg::Slots; i++) if (m_prio[i] > top) top = m_prio[i];
          m_active[idx] = 1; m_done[idx] = 0;
          m_prio[idx] = (top == 8'hff) ? 8'hff : top + 8'd1;
          refresh_led(now);
          ok = 1;
        end
      end
      psled_pkg::CMD_UPDATE: begin
        refresh_led(now);
        ok = 1;
      end
      default: ok = 0;
    endcase
    return {ok, m_drive};
  endfunction

  // Send one transaction after a random gap; hold until accepted
  task automatic send_cmd(logic [2:0] cmd, logic [15:0] key, logic [2:0] color,
      logic [7:0] prio, logic [15:0] period, logic [7:0] target, logic act,
      logic [31:0] now);
    int gap = $urandom_range(0, 7);
    if (gap > 0) begin
      cmd_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_valid_i <= 1'b1; cmd_i <= cmd; status_key_i <= key; led_color_i <= color;
    prio_level_i <= prio; blink_period_i <= period; blink_target_i <= target;
    make_active_i <= act; now_ms_i <= now;
    @(posedge clk_i);
    while (cmd_stall_o) @(posedge clk_i);
    pending_q.push_back(predict_led(cmd, key, color, prio, period, target, act, now));
    sent++;
    @(negedge clk_i);
  endtask

  // Random stall per result, plus one long hold-off when requested
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) res_stall_i <= 1'b1;
      else if (res_valid_o) begin
        int w = $urandom_range(0, 7);
        if (w > 0 && $urandom_range(0, 1)) begin
          res_stall_i <= 1'b1;
          repeat (w) @(negedge clk_i);
        end
        res_stall_i <= 1'b0;
      end else res_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && res_valid_o && !res_stall_i) begin
      logic [3:0] exp_r;
      got++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result ok=%0d led=%0d", ok_o, led_rgb_o);
      end else begin
        exp_r = pending_q.pop_front();
        if (exp_r[3] !== ok_o || exp_r[2:0] !== led_rgb_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp ok=%0d led=%0d got ok=%0d led=%0d",
                     exp_r[3], exp_r[2:0], ok_o, led_rgb_o);
        end
      end
    end
    if (cycles > 400000) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  function automatic logic [15:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 11));
  endfunction

  task automatic tick(int step);
    clock_ms = clock_ms + step;
  endtask

  // Field extremes, each command, duplicate and missing keys, unknown codes
  task automatic test_directed();
    send_cmd(psled_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(psled_pkg::CMD_SET_ACT, 16'hffff, 0, 0, 0, 0, 1, 0);
    send_cmd(psled_pkg::CMD_SET_PRI, 16'h1234, 0, 8'hff, 0, 0, 0, 0);
    send_cmd(psled_pkg::CMD_DISPLAY, 16'h1234, 0, 0, 0, 0, 0, 0);
    send_cmd(psled_pkg::CMD_CREATE, 16'hffff, 3'd7, 8'hff, 16'hffff, 8'hff, 1,
             32'hffffffff);
    send_cmd(psled_pkg::CMD_CREATE, 16'hffff, 3'd1, 8'd1, 16'd0, 8'd0, 0, 0);
    send_cmd(psled_pkg::CMD_CREATE, 16'h0000, 3'd5, 8'd10, 16'd0, 8'd0, 0, 0);
    send_cmd(psled_pkg::CMD_SET_ACT, 16'h0000, 0, 0, 0, 0, 1, 0);
    send_cmd(psled_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, 0, 32'd5);
    send_cmd(psled_pkg::CMD_CREATE, 16'h0002, 3'd2, 8'd0, 16'd2, 8'd2, 0, 0);
    send_cmd(psled_pkg::CMD_DISPLAY, 16'h0002, 0, 0, 0, 0, 0, 32'd10);
    for (int t = 0; t < 8; t++)
      send_cmd(psled_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, 0, 32'd13 + 3 * t);
    send_cmd(psled_pkg::CMD_DISPLAY, 16'hffff, 0, 0, 0, 0, 0, 32'hfffffff0);
    send_cmd(psled_pkg::CMD_DISPLAY, 16'h0000, 0, 0, 0, 0, 0, 32'd3);
    send_cmd(psled_pkg::CMD_SET_PRI, 16'h0000, 0, 8'd0, 0, 0, 0, 0);
    send_cmd(3'd5, 0, 0, 0, 0, 0, 0, 0);
    send_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0);
  endtask

  // Create, activate and blink entries; mostly updates with advancing time
  task automatic test_random(int count);
    for (int n = 0; n < count; n++) begin
      int r = $urandom_range(0, 99);
      logic [2:0] cmd;
      if (r < 12) cmd = psled_pkg::CMD_CREATE;
      else if (r < 24) cmd = psled_pkg::CMD_SET_ACT;
      else if (r < 32) cmd = psled_pkg::CMD_SET_PRI;
      else if (r < 42) cmd = psled_pkg::CMD_DISPLAY;
      else if (r < 97) cmd = psled_pkg::CMD_UPDATE;
      else cmd = 3'($urandom_range(5, 7));
      tick($urandom_range(0, 6));
      send_cmd(cmd, pick_key(), 3'($urandom),
               $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 4)),
               $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 4)),
               $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
               1'($urandom),
               $urandom_range(0, 19) == 0 ? $urandom : clock_ms);
    end
  endtask

  // Stall the result side for a long stretch while commands keep coming
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    for (int i = 0; i < psled_pkg::Slots; i++) begin
      m_valid[i] = 0; m_key[i] = 0; m_active[i] = 0; m_color[i] = 0;
      m_period[i] = 0; m_target[i] = 0; m_done[i] = 0; m_prio[i] = 0;
    end
    m_next = 0; m_shown = 0; m_blink = 0; m_prev_blink = 0; m_last_ms = 0; m_drive = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(1810);
    cmd_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("covered %0d commands, %0d results checked", sent, got);
    if (errors == 0 && pending_q.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
